// File: rtl/swt_pkg.sv
`timescale 1ns / 1ps

package swt_pkg;

  localparam int unsigned TICK_W = 32;
  localparam int unsigned ID_W   = 7;

  typedef logic [TICK_W-1:0] tick_t;
  typedef logic [ID_W-1:0]   id_t;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_START  = 2'd1,
    KIND_CANCEL = 2'd2
  } kind_e;

  typedef enum logic {
    EV_START_REPLY = 1'b0,
    EV_EXPIRED     = 1'b1
  } event_e;

  typedef struct packed {
    kind_e kind;
    tick_t delay;
    id_t   handle;
  } in_req_t;

  typedef struct packed {
    event_e event_res;
    id_t    timer_id;
    logic   last;
  } out_res_t;

  // controller -> datapath
  typedef struct packed {
    logic tick_begin;   // bump tick count, rewind scan
    logic start_begin;  // latch delay, rewind scan
    logic cancel;       // free slot named by handle
    logic idx_inc;      // advance scan index
    logic ram_rd;       // read deadline of current slot
    logic claim;        // take current slot, send start reply
    logic full;         // send table-full reply
    logic cmp_step;     // evaluate expiry of current slot
    logic flush;        // send held report marked last
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cur_active;
    logic idx_last;
    logic expired;
    logic pend_valid;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/swt_ram.sv
`timescale 1ns / 1ps

module swt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/swt_ctrl.sv
`timescale 1ns / 1ps

module swt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  swt_pkg::kind_e       kind_i,
  input  swt_pkg::sts_t        sts_i,
  output logic                 in_stall_o,
  output swt_pkg::cmd_t        cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_FIND     = 5'b00010,
    ST_TICK_RD  = 5'b00100,
    ST_TICK_CMP = 5'b01000,
    ST_FLUSH    = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (kind_i)
            swt_pkg::KIND_TICK: begin
              cmd_o.tick_begin = 1'b1;
              state_d          = ST_TICK_RD;
            end
            swt_pkg::KIND_START: begin
              cmd_o.start_begin = 1'b1;
              state_d           = ST_FIND;
            end
            swt_pkg::KIND_CANCEL: begin
              cmd_o.cancel = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_FIND: begin
        if (!sts_i.cur_active) begin
          if (sts_i.out_free) begin
            cmd_o.claim = 1'b1;
            state_d     = ST_IDLE;
          end
        end else if (sts_i.idx_last) begin
          if (sts_i.out_free) begin
            cmd_o.full = 1'b1;
            state_d    = ST_IDLE;
          end
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      ST_TICK_RD: begin
        if (sts_i.cur_active) begin
          cmd_o.ram_rd = 1'b1;
          state_d      = ST_TICK_CMP;
        end else if (sts_i.idx_last) begin
          state_d = ST_FLUSH;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      ST_TICK_CMP: begin
        // a new expiry pushes out the held report, which needs the output free
        if (!(sts_i.expired && sts_i.pend_valid && !sts_i.out_free)) begin
          cmd_o.cmp_step = 1'b1;
          if (sts_i.idx_last) begin
            state_d = ST_FLUSH;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = ST_TICK_RD;
          end
        end
      end
      ST_FLUSH: begin
        if (!sts_i.pend_valid) begin
          state_d = ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

// File: rtl/swt_dp.sv
`timescale 1ns / 1ps

module swt_dp #(
  parameter int unsigned TIMER_SLOTS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  swt_pkg::in_req_t  in_req_i,
  input  swt_pkg::cmd_t     cmd_i,
  output swt_pkg::sts_t     sts_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output swt_pkg::out_res_t out_res_o
);

  localparam int unsigned IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

  swt_pkg::tick_t          tick_q, tick_d;
  swt_pkg::tick_t          delay_q;
  logic [TIMER_SLOTS-1:0]  active_q, active_d;
  logic [IDX_W-1:0]        idx_q, idx_d;
  logic                    pend_valid_q, pend_valid_d;
  swt_pkg::id_t            pend_id_q, pend_id_d;
  logic                    out_valid_q, out_valid_d;
  swt_pkg::out_res_t       out_q, out_d;

  logic                    ram_we, ram_re;
  swt_pkg::tick_t          dl_rd;
  swt_pkg::tick_t          dl_wr;
  swt_pkg::tick_t          diff;
  logic                    expired;
  logic                    handle_ok;
  logic [IDX_W-1:0]        hidx;
  swt_pkg::id_t            cur_id;
  logic                    out_free;

  assign dl_wr     = tick_q + delay_q;
  // deadline minus count; expired when, as signed, it is at most zero
  assign diff      = dl_rd - tick_q;
  assign expired   = (diff == '0) || diff[swt_pkg::TICK_W-1];
  assign handle_ok = (in_req_i.handle != '0) &&
                     (in_req_i.handle <= swt_pkg::id_t'(TIMER_SLOTS));
  assign hidx      = IDX_W'(in_req_i.handle - swt_pkg::id_t'(1));
  assign cur_id    = swt_pkg::id_t'(idx_q) + swt_pkg::id_t'(1);
  assign out_free  = !out_valid_q || !out_stall_i;

  swt_ram #(
    .WIDTH (swt_pkg::TICK_W),
    .DEPTH (TIMER_SLOTS)
  ) u_deadline_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (idx_q),
    .wdata_i (dl_wr),
    .rdata_o (dl_rd)
  );

  always_comb begin
    tick_d       = tick_q;
    active_d     = active_q;
    idx_d        = idx_q;
    pend_valid_d = pend_valid_q;
    pend_id_d    = pend_id_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;

    if (cmd_i.tick_begin) begin
      tick_d       = tick_q + swt_pkg::tick_t'(1);
      idx_d        = '0;
      pend_valid_d = 1'b0;
    end
    if (cmd_i.start_begin) begin
      idx_d = '0;
    end
    if (cmd_i.cancel && handle_ok) begin
      active_d[hidx] = 1'b0;
    end
    if (cmd_i.idx_inc) begin
      idx_d = idx_q + IDX_W'(1);
    end
    if (cmd_i.ram_rd) begin
      ram_re = 1'b1;
    end
    if (cmd_i.claim) begin
      active_d[idx_q] = 1'b1;
      ram_we          = 1'b1;
      out_valid_d     = 1'b1;
      out_d           = '{event_res: swt_pkg::EV_START_REPLY, timer_id: cur_id, last: 1'b1};
    end
    if (cmd_i.full) begin
      out_valid_d = 1'b1;
      out_d       = '{event_res: swt_pkg::EV_START_REPLY, timer_id: '0, last: 1'b1};
    end
    // expiry reports are held one behind so the final one can be marked last
    if (cmd_i.cmp_step && expired) begin
      active_d[idx_q] = 1'b0;
      pend_valid_d    = 1'b1;
      pend_id_d       = cur_id;
      if (pend_valid_q) begin
        out_valid_d = 1'b1;
        out_d       = '{event_res: swt_pkg::EV_EXPIRED, timer_id: pend_id_q, last: 1'b0};
      end
    end
    if (cmd_i.flush) begin
      pend_valid_d = 1'b0;
      out_valid_d  = 1'b1;
      out_d        = '{event_res: swt_pkg::EV_EXPIRED, timer_id: pend_id_q, last: 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q       <= '0;
      active_q     <= '0;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      tick_q       <= tick_d;
      active_q     <= active_d;
      idx_q        <= idx_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_begin) begin
      delay_q <= in_req_i.delay;
    end
    pend_id_q <= pend_id_d;
    out_q     <= out_d;
  end

  always_comb begin
    sts_o            = '0;
    sts_o.cur_active = active_q[idx_q];
    sts_o.idx_last   = (idx_q == IDX_W'(TIMER_SLOTS - 1));
    sts_o.expired    = expired;
    sts_o.pend_valid = pend_valid_q;
    sts_o.out_free   = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

// File: rtl/software_timer_slot_table_top.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// --------  ---------  ------------------------  ----------------------------
// request   in         in_valid_i / in_stall_o   in_req_i   (kind, delay, handle)
// result    out        out_valid_o / out_stall_i out_res_o  (event_res, timer_id, last)
//
// One request at a time. Cancel is done in the idle state; start scans from
// slot 0 to the first free slot or the last slot; tick visits every slot and
// reads each active slot's deadline (single-port RAM, registered read) to compare it.
// Reset clears the tick count and all active bits; the deadline RAM is not
// cleared. A stalled result holds in the output register; the scan waits only
// when a new result finds it still occupied.

module software_timer_slot_table_top #(
  parameter int unsigned TIMER_SLOTS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  swt_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output swt_pkg::out_res_t out_res_o
);

  swt_pkg::cmd_t cmd;
  swt_pkg::sts_t sts;

  swt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (in_req_i.kind),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  swt_dp #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

endmodule

// File: bench/tb_software_timer_slot_table_top.sv
`timescale 1ns / 1ps

module tb_software_timer_slot_table_top;
  import swt_pkg::*;

  localparam int unsigned SLOTS       = 16;
  localparam logic [1:0]  KIND_UNUSED = 2'd3;
  localparam int unsigned RANDOM_REQS = 90;  // per idling phase
  localparam int unsigned DRAIN_CAP   = 50000;
  localparam int unsigned TAIL_CYCLES = 100;

  // Expected-result store plus a private copy of the timer table.
  class timer_scoreboard;
    tick_t       tick_count;
    bit          active[SLOTS];
    tick_t       deadline[SLOTS];
    out_res_t    expected_q[$];
    int unsigned errors;

    function new();
      tick_count = '0;
      errors     = 0;
      foreach (active[i]) begin
        active[i]   = 1'b0;
        deadline[i] = '0;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    function void note_request(in_req_t r);
      out_res_t res;
      out_res_t expired_q[$];
      tick_t    diff;
      int       slot;
      case (r.kind)
        KIND_TICK: begin
          tick_count = tick_count + 1;
          for (int i = 0; i < SLOTS; i++) begin
            diff = deadline[i] - tick_count;
            if (active[i] && $signed(diff) <= 0) begin
              active[i]     = 1'b0;
              res.event_res = EV_EXPIRED;
              res.timer_id  = id_t'(i + 1);
              res.last      = 1'b0;
              expired_q.push_back(res);
            end
          end
          if (expired_q.size() > 0) expired_q[expired_q.size() - 1].last = 1'b1;
          foreach (expired_q[i]) expected_q.push_back(expired_q[i]);
        end
        KIND_START: begin
          slot = -1;
          for (int i = 0; i < SLOTS; i++) begin
            if (!active[i] && slot < 0) slot = i;
          end
          res.event_res = EV_START_REPLY;
          res.last      = 1'b1;
          res.timer_id  = '0;  // table full
          if (slot >= 0) begin
            active[slot]   = 1'b1;
            deadline[slot] = tick_count + r.delay;
            res.timer_id   = id_t'(slot + 1);
          end
          expected_q.push_back(res);
        end
        KIND_CANCEL: begin
          if (r.handle >= 1 && r.handle <= SLOTS) active[r.handle - 1] = 1'b0;
        end
        default: ;
      endcase
    endfunction

    task check_result(out_res_t got);
      out_res_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result ev=%0d id=%0d last=%0b",
                         got.event_res, got.timer_id, got.last));
        return;
      end
      want = expected_q.pop_front();
      if (got.event_res !== want.event_res)
        report($sformatf("event_res got %0d want %0d (id %0d)",
                         got.event_res, want.event_res, want.timer_id));
      if (got.timer_id !== want.timer_id)
        report($sformatf("timer_id got %0d want %0d", got.timer_id, want.timer_id));
      if (got.last !== want.last)
        report($sformatf("last got %0b want %0b (id %0d)",
                         got.last, want.last, want.timer_id));
    endtask
  endclass

  logic     clk      = 1'b0;
  logic     rst_n    = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_req   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_res_t out_res;

  int unsigned send_idle_pct = 20;
  int unsigned recv_idle_pct = 49;

  timer_scoreboard sb = new();

  software_timer_slot_table_top #(
    .TIMER_SLOTS(SLOTS)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_res_o  (out_res)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_res);
  end

  // Entered and left just after a falling edge.
  task automatic send_req(input in_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_req   = r;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    int unsigned waited;
    waited   = 0;
    in_valid = 1'b0;
    while (sb.pending() != 0 && waited < DRAIN_CAP) begin
      @(negedge clk);
      waited++;
    end
  endtask

  function automatic in_req_t make_req(logic [1:0] kind, tick_t delay, id_t handle);
    in_req_t r;
    r.kind   = kind_e'(kind);
    r.delay  = delay;
    r.handle = handle;
    return r;
  endfunction

  function automatic in_req_t random_req();
    in_req_t     r;
    int unsigned pick;
    int unsigned dsel;
    r.kind   = KIND_TICK;
    r.delay  = $urandom();
    r.handle = id_t'($urandom_range(127));
    pick     = $urandom_range(99);
    if (pick < 40) begin
      r.kind = KIND_TICK;
    end else if (pick < 75) begin
      r.kind = KIND_START;
      dsel   = $urandom_range(9);
      // mostly short timers so expiries keep coming; a few near the sign boundary
      if (dsel < 6)       r.delay = tick_t'($urandom_range(40));
      else if (dsel == 6) r.delay = 32'h7FFF_FFF0 + tick_t'($urandom_range(31));
      else if (dsel == 7) r.delay = 32'hFFFF_FFF0 + tick_t'($urandom_range(15));
    end else if (pick < 95) begin
      r.kind = KIND_CANCEL;
      if ($urandom_range(3) != 0) r.handle = id_t'($urandom_range(SLOTS, 1));
    end else begin
      r.kind = kind_e'(KIND_UNUSED);
    end
    return r;
  endfunction

  task automatic run_directed();
    send_req(make_req(KIND_TICK, '0, '0));            // tick on an empty table
    send_req(make_req(KIND_START, '0, '0));           // zero delay
    send_req(make_req(KIND_TICK, '0, '0));
    send_req(make_req(KIND_START, 32'hFFFF_FFFF, '0)); // deadline wraps
    send_req(make_req(KIND_START, 32'h8000_0000, '0));
    send_req(make_req(KIND_START, 32'h7FFF_FFFF, '0));
    send_req(make_req(KIND_START, 32'd2, 7'd0));
    send_req(make_req(KIND_CANCEL, '0, 7'd0));        // out of range, low
    send_req(make_req(KIND_CANCEL, '1, 7'd127));      // out of range, high
    send_req(make_req(KIND_CANCEL, '0, 7'd16));       // inactive slot
    send_req(make_req(KIND_CANCEL, '0, 7'd3));
    send_req(make_req(KIND_UNUSED, '1, 7'd1));
    send_req(make_req(KIND_TICK, '0, '0));
    send_req(make_req(KIND_TICK, '0, '0));
    // fill the table, overflow it, then expire almost all in one tick
    repeat (SLOTS) send_req(make_req(KIND_START, 32'd1, '0));
    send_req(make_req(KIND_TICK, '0, '0));
  endtask

  initial begin
    int unsigned counted;
    in_req_t     r;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 49 : 0;
      recv_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 20 : 0;
      if (ph == 0) run_directed();
      counted = 0;
      while (counted < RANDOM_REQS) begin
        if ($urandom_range(99) == 0) wait_drained();
        r = random_req();
        counted++;
        send_req(r);
      end
      wait_drained();
    end

    in_valid = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));

    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: files.f
rtl/swt_pkg.sv
rtl/swt_ram.sv
rtl/swt_ctrl.sv
rtl/swt_dp.sv
rtl/software_timer_slot_table_top.sv
bench/tb_software_timer_slot_table_top.sv
